FILE: rtl/ngll_pkg.sv
package ngll_pkg;

    // one byte of the sentence with its end marker
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_sentence;
    } in_t;

    // one parsed position report
    typedef struct packed {
        logic        header_match;
        logic [33:0] lat_scaled;
        logic [33:0] lon_scaled;
        logic [7:0]  lat_hemisphere;
        logic [7:0]  lon_hemisphere;
        logic [23:0] time_digits;
    } out_t;

    // field limits
    localparam logic [3:0] FIELD_CHARS     = 4'd10;
    localparam logic [2:0] FRACTION_DIGITS = 3'd5;
    localparam logic [2:0] SCALE_EXP       = 3'd5;
    localparam logic [3:0] HEADER_LEN      = 4'd6;
    localparam logic [3:0] TIME_CHARS      = 4'd6;

    // number range
    localparam logic [33:0] NUM_MAX       = 34'd9999999999;
    localparam logic [33:0] NUM_MAX_DIV10 = 34'd999999999;

    // "$GPGLL"
    localparam logic [47:0] HEADER_GLL = 48'h244750474C4C;

    // ascii codes
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // field numbers within the sentence
    localparam logic [2:0] FIELD_HEADER = 3'd0;
    localparam logic [2:0] FIELD_LAT    = 3'd1;
    localparam logic [2:0] FIELD_NS     = 3'd2;
    localparam logic [2:0] FIELD_LON    = 3'd3;
    localparam logic [2:0] FIELD_EW     = 3'd4;
    localparam logic [2:0] FIELD_TIME   = 3'd5;
    localparam logic [2:0] FIELD_LAST   = 3'd7;

    // field close request from the lexer
    typedef struct packed {
        logic        valid;
        logic        write;
        logic [2:0]  field;
        logic [33:0] accum;
        logic [33:0] accum_div10;
        logic [2:0]  frac_count;
        logic [3:0]  char_pos;
        logic        emit;
        logic        header_match;
    } close_req_t;

    // scaled close request to the store stage
    typedef struct packed {
        logic        valid;
        logic        write;
        logic [2:0]  field;
        logic [50:0] product;
        logic        use_div;
        logic [33:0] accum_div10;
        logic [7:0]  letter;
        logic [23:0] time_val;
        logic        emit;
        logic        header_match;
    } scale_req_t;

    // powers of ten for the decimal scaling
    function automatic logic [16:0] pow10(input logic [2:0] k);
        logic [16:0] p;
        case (k)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/nmea_gll_sentence_parser.sv
// Parses NMEA GLL sentences fed one byte per request on the s_ channel, the
// last byte flagged by end_of_sentence. Field 0 must read exactly "$GPGLL";
// otherwise header_match is 0 and the stored position is left alone.
// Latitude and longitude are reported as the field value divided by 100 in
// units of 1e-7, saturating at 9999999999; hemisphere letters and the six
// hhmmss time digits (packed BCD) are kept alongside. Stored values persist
// from sentence to sentence. One byte is taken every clock cycle unless the
// pipeline holds; a result request appears on the m_ channel once its last
// byte has passed the four-register pipeline (input, field parse, decimal
// scaling multiply, store and output). While a result waits on m_ready the
// whole pipeline holds.
module nmea_gll_sentence_parser #(
    parameter logic [3:0] FIELD_CHARS     = ngll_pkg::FIELD_CHARS,
    parameter logic [2:0] FRACTION_DIGITS = ngll_pkg::FRACTION_DIGITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ngll_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output ngll_pkg::out_t m_payload
);

    logic                 en;
    ngll_pkg::close_req_t close_req;
    ngll_pkg::scale_req_t scale_req;

    // pipeline advances unless a result is held back
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    ngll_lexer #(
        .FIELD_CHARS     (FIELD_CHARS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s_valid   (s_valid),
        .s_payload (s_payload),
        .close_req (close_req)
    );

    ngll_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .close_req (close_req),
        .scale_req (scale_req)
    );

    ngll_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .scale_req (scale_req),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

endmodule

FILE: rtl/ngll_lexer.sv
module ngll_lexer #(
    parameter logic [3:0] FIELD_CHARS     = ngll_pkg::FIELD_CHARS,
    parameter logic [2:0] FRACTION_DIGITS = ngll_pkg::FRACTION_DIGITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                s_valid,
    input  ngll_pkg::in_t       s_payload,
    output ngll_pkg::close_req_t close_req
);

    logic                 in_valid_reg;
    ngll_pkg::in_t        in_data_reg;

    logic [2:0]           field_reg,  field_next;
    logic [3:0]           cpos_reg,   cpos_next;
    logic [47:0]          hdr_reg,    hdr_next;
    logic                 hfail_reg,  hfail_next;
    logic [33:0]          acc_reg,    acc_next;
    logic [33:0]          div10_reg,  div10_next;
    logic [2:0]           frac_reg,   frac_next;
    logic                 point_reg,  point_next;
    logic                 stop_reg,   stop_next;
    ngll_pkg::close_req_t req_reg,    req_next;

    logic [7:0]  c;
    logic        last;
    logic        is_comma;
    logic        is_digit;
    logic        do_close;
    logic        hdr_bad;
    logic        hfail_after;
    logic [7:0]  digit_code;
    logic [33:0] acc_mac;
    logic [33:0] acc_div;
    logic [3:0]  t_cpos;
    logic [47:0] t_hdr;
    logic [33:0] t_acc;
    logic [33:0] t_div10;
    logic [2:0]  t_frac;
    logic        t_point;
    logic        t_stop;

    // per byte parse: take the byte, then close the field on comma or end
    always_comb begin
        c          = in_data_reg.char_in;
        last       = in_data_reg.end_of_sentence;
        is_comma   = (c == ngll_pkg::CHAR_COMMA);
        is_digit   = (c >= ngll_pkg::CHAR_ZERO) && (c <= ngll_pkg::CHAR_NINE);
        digit_code = c - ngll_pkg::CHAR_ZERO;

        // saturating multiply-by-ten accumulate
        if (acc_reg > ngll_pkg::NUM_MAX_DIV10) begin
            acc_mac = ngll_pkg::NUM_MAX;
            acc_div = ngll_pkg::NUM_MAX_DIV10;
        end else begin
            acc_mac = (acc_reg << 3) + (acc_reg << 1) + {30'd0, digit_code[3:0]};
            acc_div = acc_reg;
        end

        t_cpos  = cpos_reg;
        t_hdr   = hdr_reg;
        t_acc   = acc_reg;
        t_div10 = div10_reg;
        t_frac  = frac_reg;
        t_point = point_reg;
        t_stop  = stop_reg;

        // take a byte that is not a separator
        if (!is_comma && (cpos_reg < FIELD_CHARS)) begin
            t_cpos = cpos_reg + 4'd1;
            if (field_reg == ngll_pkg::FIELD_HEADER) begin
                if (cpos_reg < ngll_pkg::HEADER_LEN) begin
                    t_hdr = {hdr_reg[39:0], c};
                end
            end else if (!hfail_reg) begin
                if ((field_reg == ngll_pkg::FIELD_LAT) ||
                    (field_reg == ngll_pkg::FIELD_LON)) begin
                    if (!stop_reg) begin
                        if (is_digit) begin
                            if (!point_reg) begin
                                t_acc   = acc_mac;
                                t_div10 = acc_div;
                            end else if (frac_reg < FRACTION_DIGITS) begin
                                t_acc   = acc_mac;
                                t_div10 = acc_div;
                                t_frac  = frac_reg + 3'd1;
                            end
                        end else if ((c == ngll_pkg::CHAR_POINT) && !point_reg) begin
                            t_point = 1'b1;
                        end else begin
                            t_stop = 1'b1;
                        end
                    end
                end else if ((field_reg == ngll_pkg::FIELD_NS) ||
                             (field_reg == ngll_pkg::FIELD_EW)) begin
                    if (cpos_reg == 4'd0) begin
                        t_acc = {26'd0, c};
                    end
                end else if (field_reg == ngll_pkg::FIELD_TIME) begin
                    if (cpos_reg < ngll_pkg::TIME_CHARS) begin
                        t_acc = {10'd0, acc_reg[19:0], c[3:0]};
                    end
                end
            end
        end

        // field close and end of sentence
        do_close    = is_comma || last;
        hdr_bad     = (t_cpos != ngll_pkg::HEADER_LEN) || (t_hdr != ngll_pkg::HEADER_GLL);
        hfail_after = hfail_reg ||
                      (do_close && (field_reg == ngll_pkg::FIELD_HEADER) && hdr_bad);

        field_next = field_reg;
        cpos_next  = t_cpos;
        hdr_next   = t_hdr;
        hfail_next = hfail_after;
        acc_next   = t_acc;
        div10_next = t_div10;
        frac_next  = t_frac;
        point_next = t_point;
        stop_next  = t_stop;

        if (do_close) begin
            if (field_reg != ngll_pkg::FIELD_LAST) begin
                field_next = field_reg + 3'd1;
            end
            cpos_next  = 4'd0;
            acc_next   = 34'd0;
            div10_next = 34'd0;
            frac_next  = 3'd0;
            point_next = 1'b0;
            stop_next  = 1'b0;
        end
        if (last) begin
            field_next = ngll_pkg::FIELD_HEADER;
            hdr_next   = 48'd0;
            hfail_next = 1'b0;
        end

        // request to the scaling stage
        req_next.valid        = in_valid_reg && do_close;
        req_next.write        = !hfail_reg && (field_reg != ngll_pkg::FIELD_HEADER) &&
                                (field_reg <= ngll_pkg::FIELD_TIME);
        req_next.field        = field_reg;
        req_next.accum        = t_acc;
        req_next.accum_div10  = t_div10;
        req_next.frac_count   = t_frac;
        req_next.char_pos     = t_cpos;
        req_next.emit         = last;
        req_next.header_match = !hfail_after;
    end

    // input register, parse state and close request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            field_reg    <= 3'd0;
            cpos_reg     <= 4'd0;
            hdr_reg      <= 48'd0;
            hfail_reg    <= 1'b0;
            acc_reg      <= 34'd0;
            div10_reg    <= 34'd0;
            frac_reg     <= 3'd0;
            point_reg    <= 1'b0;
            stop_reg     <= 1'b0;
            req_reg      <= '0;
        end else if (en) begin
            in_valid_reg <= s_valid;
            in_data_reg  <= s_payload;
            req_reg      <= req_next;
            if (in_valid_reg) begin
                field_reg <= field_next;
                cpos_reg  <= cpos_next;
                hdr_reg   <= hdr_next;
                hfail_reg <= hfail_next;
                acc_reg   <= acc_next;
                div10_reg <= div10_next;
                frac_reg  <= frac_next;
                point_reg <= point_next;
                stop_reg  <= stop_next;
            end
        end
    end

    assign close_req = req_reg;

endmodule

FILE: rtl/ngll_scaler.sv
module ngll_scaler (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  ngll_pkg::close_req_t close_req,
    output ngll_pkg::scale_req_t scale_req
);

    ngll_pkg::scale_req_t req_reg, req_next;

    logic [16:0] factor;
    logic [2:0]  time_n;
    logic [2:0]  time_pad;

    // decimal scaling product and time digit alignment
    always_comb begin
        factor   = ngll_pkg::pow10(ngll_pkg::SCALE_EXP - close_req.frac_count);
        time_n   = (close_req.char_pos < ngll_pkg::TIME_CHARS) ?
                   close_req.char_pos[2:0] : ngll_pkg::TIME_CHARS[2:0];
        time_pad = ngll_pkg::TIME_CHARS[2:0] - time_n;

        req_next.valid        = close_req.valid;
        req_next.write        = close_req.write;
        req_next.field        = close_req.field;
        req_next.product      = 51'(close_req.accum) * 51'(factor);
        req_next.use_div      = close_req.frac_count > ngll_pkg::SCALE_EXP;
        req_next.accum_div10  = close_req.accum_div10;
        req_next.letter       = close_req.accum[7:0];
        req_next.time_val     = close_req.accum[23:0] << {time_pad, 2'b00};
        req_next.emit         = close_req.emit;
        req_next.header_match = close_req.header_match;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg <= '0;
        end else if (en) begin
            req_reg <= req_next;
        end
    end

    assign scale_req = req_reg;

endmodule

FILE: rtl/ngll_store.sv
module ngll_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  ngll_pkg::scale_req_t scale_req,
    output logic                 m_valid,
    output ngll_pkg::out_t       m_payload
);

    logic [33:0]    lat_reg,  lat_next;
    logic [33:0]    lon_reg,  lon_next;
    logic [7:0]     ns_reg,   ns_next;
    logic [7:0]     ew_reg,   ew_next;
    logic [23:0]    time_reg, time_next;
    logic           out_valid_reg;
    ngll_pkg::out_t out_data_reg, out_data_next;

    logic [33:0] scaled;

    // saturate the scaled number and update the field stores
    always_comb begin
        if (scale_req.use_div) begin
            scaled = scale_req.accum_div10;
        end else if (scale_req.product > 51'(ngll_pkg::NUM_MAX)) begin
            scaled = ngll_pkg::NUM_MAX;
        end else begin
            scaled = scale_req.product[33:0];
        end

        lat_next  = lat_reg;
        lon_next  = lon_reg;
        ns_next   = ns_reg;
        ew_next   = ew_reg;
        time_next = time_reg;
        if (scale_req.valid && scale_req.write) begin
            case (scale_req.field)
                ngll_pkg::FIELD_LAT:  lat_next  = scaled;
                ngll_pkg::FIELD_NS:   ns_next   = scale_req.letter;
                ngll_pkg::FIELD_LON:  lon_next  = scaled;
                ngll_pkg::FIELD_EW:   ew_next   = scale_req.letter;
                ngll_pkg::FIELD_TIME: time_next = scale_req.time_val;
                default: ;
            endcase
        end

        out_data_next.header_match   = scale_req.header_match;
        out_data_next.lat_scaled     = lat_next;
        out_data_next.lon_scaled     = lon_next;
        out_data_next.lat_hemisphere = ns_next;
        out_data_next.lon_hemisphere = ew_next;
        out_data_next.time_digits    = time_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg       <= 34'd0;
            lon_reg       <= 34'd0;
            ns_reg        <= 8'd0;
            ew_reg        <= 8'd0;
            time_reg      <= 24'd0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
            ns_reg        <= ns_next;
            ew_reg        <= ew_next;
            time_reg      <= time_next;
            out_valid_reg <= scale_req.valid && scale_req.emit;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

endmodule
